### src/srfr_pkg.sv
// ---------------------------------------------------------------------------
// srfr_pkg
// shared constants, codes and types of the serial frame ring receiver
// ---------------------------------------------------------------------------
package srfr_pkg;

    // ring geometry
    localparam int RING_DEPTH = 64;
    localparam int PTR_W      = $clog2(RING_DEPTH);

    // field widths
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 6;

    // opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PARITY   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_STOP     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERRUN  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd5;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd6;

    // special characters
    localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
    localparam logic [BYTE_W-1:0] CH_XON    = 8'h11;
    localparam logic [BYTE_W-1:0] CH_XOFF   = 8'h13;
    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] KEY_IDLE  = 8'hAA;

    // bytes that follow the dollar sign in a good frame: depth, key, cr
    localparam int FRAME_TAIL = 3;

    typedef struct packed {
        logic              opcode;
        logic [BYTE_W-1:0] rx_byte;
        logic              parity_error;
        logic              stop_error;
        logic              overrun_error;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   popped_byte;
        logic [COUNT_W-1:0]  entry_count;
        logic [BYTE_W-1:0]   depth_reading;
        logic [BYTE_W-1:0]   remote_key;
        logic                send_enabled;
    } rsp_item_t;

    typedef struct packed {
        logic idle;
        logic done;
    } ctrl_stat_t;

    // pointer advance with wrap at the ring depth
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] nxt;
        if (ptr == PTR_W'(RING_DEPTH - 1))
        begin
            nxt = '0;
        end
        else
        begin
            nxt = ptr + PTR_W'(1);
        end
        return nxt;
    endfunction

    // bytes held between read and write pointer
    function automatic logic [PTR_W-1:0] ring_held(input logic [PTR_W-1:0] wp,
                                                   input logic [PTR_W-1:0] rp);
        logic [PTR_W:0] diff;
        diff = {1'b0, wp} - {1'b0, rp};
        if (wp < rp)
        begin
            diff = diff + (PTR_W+1)'(RING_DEPTH);
        end
        return diff[PTR_W-1:0];
    endfunction

endpackage

### src/srfr_if.sv
// ---------------------------------------------------------------------------
// srfr channel interfaces
// valid/ready channels for request items, result items and config writes
// ---------------------------------------------------------------------------
interface srfr_req_if;
    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic [srfr_pkg::BYTE_W-1:0] rx_byte;
    logic                     parity_error;
    logic                     stop_error;
    logic                     overrun_error;

    modport source (output valid, opcode, rx_byte, parity_error, stop_error,
                    overrun_error, input ready);
    modport sink   (input valid, opcode, rx_byte, parity_error, stop_error,
                    overrun_error, output ready);
endinterface

interface srfr_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [srfr_pkg::STATUS_W-1:0] status;
    logic [srfr_pkg::BYTE_W-1:0]   popped_byte;
    logic [srfr_pkg::COUNT_W-1:0]  entry_count;
    logic [srfr_pkg::BYTE_W-1:0]   depth_reading;
    logic [srfr_pkg::BYTE_W-1:0]   remote_key;
    logic                          send_enabled;

    modport source (output valid, status, popped_byte, entry_count, depth_reading,
                    remote_key, send_enabled, input ready);
    modport sink   (input valid, status, popped_byte, entry_count, depth_reading,
                    remote_key, send_enabled, output ready);
endinterface

interface srfr_cfg_if;
    logic valid;
    logic ready;
    logic frame_mode;

    modport source (output valid, frame_mode, input ready);
    modport sink   (input valid, frame_mode, output ready);
endinterface

### src/serial_frame_ring_receiver_core.sv
// ---------------------------------------------------------------------------
// serial_frame_ring_receiver_core
// receive byte ring with xon/xoff flow mode and dollar-framed packet mode
// ---------------------------------------------------------------------------
// results: stored, dropped, flow-control and empty-pop items give their result
//   in the cycle after acceptance; a pop with data first passes through S_POP
// a carriage return in frame mode passes S_PRIME, then walks the bytes held once it
//   is stored in S_SCAN and S_TAIL (one ring read per cycle, depth/key/cr fetch
//   included); one item at a time, next item taken once the result
//   register is free
// reset: pointers, frame bytes and state cleared, send flag and frame mode set;
//   the ring store itself is not cleared
// ---------------------------------------------------------------------------
module serial_frame_ring_receiver_core (
    input  logic         clk,
    input  logic         rst_n,
    srfr_req_if.sink     req,
    srfr_rsp_if.source   rsp,
    srfr_cfg_if.sink     cfg
);

    // mode register; the user must write it only while idle, the block does not enforce it
    logic                 frame_mode_reg;

    // result holding register, decouples the sequencer from the consumer
    logic                 out_valid_reg, out_valid_next;
    srfr_pkg::rsp_item_t  out_reg;

    srfr_pkg::req_item_t  req_item;
    srfr_pkg::rsp_item_t  res;
    srfr_pkg::ctrl_stat_t stat;
    logic                 req_fire;
    logic                 slot_free;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_mode_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            frame_mode_reg <= cfg.frame_mode;
        end
    end

    // result slot is free now or is being emptied this cycle
    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = stat.idle && slot_free;
    assign req_fire  = req.valid && req.ready;

    // gather request fields into one item
    assign req_item.opcode        = req.opcode;
    assign req_item.rx_byte       = req.rx_byte;
    assign req_item.parity_error  = req.parity_error;
    assign req_item.stop_error    = req.stop_error;
    assign req_item.overrun_error = req.overrun_error;

    // sequencer, pointers and the ring store
    srfr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_mode (frame_mode_reg),
        .req_fire   (req_fire),
        .req        (req_item),
        .stat       (stat),
        .res        (res)
    );

    // result register: load on completion, clear when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (stat.done)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (stat.done)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_reg.status;
    assign rsp.popped_byte   = out_reg.popped_byte;
    assign rsp.entry_count   = out_reg.entry_count;
    assign rsp.depth_reading = out_reg.depth_reading;
    assign rsp.remote_key    = out_reg.remote_key;
    assign rsp.send_enabled  = out_reg.send_enabled;

    // a finished item never overwrites a result still waiting
    a_done_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> slot_free)
        else $error("result produced while result register occupied");

    // the sequencer is back to idle after every result
    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |=> stat.idle)
        else $error("sequencer not idle after result");

    // only a plain ok result can carry a popped byte
    a_popped_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != srfr_pkg::ST_OK)) |-> (rsp.popped_byte == '0))
        else $error("popped byte on a non-ok result");

endmodule

### src/srfr_ram.sv
// ---------------------------------------------------------------------------
// srfr_ram
// generic single-write, single-read ram with registered read (read-old)
// ---------------------------------------------------------------------------
module srfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/srfr_ctrl.sv
// ---------------------------------------------------------------------------
// srfr_ctrl
// ring pointers, flags and the sequencer that walks the ring on a cr
// ---------------------------------------------------------------------------
module srfr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 frame_mode,
    input  logic                 req_fire,
    input  srfr_pkg::req_item_t  req,
    output srfr_pkg::ctrl_stat_t stat,
    output srfr_pkg::rsp_item_t  res
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_POP   = 5'b00010,
        S_PRIME = 5'b00100,
        S_SCAN  = 5'b01000,
        S_TAIL  = 5'b10000
    } state_t;

    localparam logic [1:0] TAIL_DEPTH = 2'd0;
    localparam logic [1:0] TAIL_KEY   = 2'd1;
    localparam logic [1:0] TAIL_LAST  = 2'd2;

    state_t                           state_reg, state_next;
    logic [srfr_pkg::PTR_W-1:0]       rp_reg, rp_next;
    logic [srfr_pkg::PTR_W-1:0]       wp_reg, wp_next;
    logic [srfr_pkg::PTR_W-1:0]       rem_reg, rem_next;
    logic [1:0]                       tail_reg, tail_next;
    logic [srfr_pkg::BYTE_W-1:0]      depth_reg, depth_next;
    logic [srfr_pkg::BYTE_W-1:0]      key_reg, key_next;
    logic                             send_reg, send_next;

    logic                             we;
    logic [srfr_pkg::BYTE_W-1:0]      rd_data;
    logic                             done;
    logic [srfr_pkg::STATUS_W-1:0]    status;
    logic [srfr_pkg::BYTE_W-1:0]      popped;

    // read address follows the next read pointer, so rd_data is ram[rp_reg]
    srfr_ram #(
        .WIDTH (srfr_pkg::BYTE_W),
        .DEPTH (srfr_pkg::RING_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (wp_reg),
        .wdata (req.rx_byte),
        .raddr (rp_next),
        .rdata (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        rem_next   = rem_reg;
        tail_next  = tail_reg;
        depth_next = depth_reg;
        key_next   = key_reg;
        send_next  = send_reg;
        we         = 1'b0;
        done       = 1'b0;
        status     = srfr_pkg::ST_OK;
        popped     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.opcode == srfr_pkg::OP_POP)
                    begin
                        if (rp_reg == wp_reg)
                        begin
                            status = srfr_pkg::ST_EMPTY;
                            done   = 1'b1;
                        end
                        else
                        begin
                            state_next = S_POP;
                        end
                    end
                    else if (!frame_mode)
                    begin
                        done = 1'b1;
                        if (req.rx_byte == srfr_pkg::CH_XON)
                        begin
                            send_next = 1'b1;
                        end
                        else if (req.rx_byte == srfr_pkg::CH_XOFF)
                        begin
                            send_next = 1'b0;
                        end
                        else if (req.rx_byte != srfr_pkg::CH_NUL)
                        begin
                            we      = 1'b1;
                            wp_next = srfr_pkg::ptr_inc(wp_reg);
                        end
                    end
                    else if (req.parity_error)
                    begin
                        status = srfr_pkg::ST_PARITY;
                        done   = 1'b1;
                    end
                    else if (req.stop_error)
                    begin
                        status = srfr_pkg::ST_STOP;
                        done   = 1'b1;
                    end
                    else if (req.overrun_error)
                    begin
                        status = srfr_pkg::ST_OVERRUN;
                        done   = 1'b1;
                    end
                    else
                    begin
                        we      = 1'b1;
                        wp_next = srfr_pkg::ptr_inc(wp_reg);
                        if (req.rx_byte == srfr_pkg::CH_CR)
                        begin
                            rem_next   = srfr_pkg::ring_held(wp_next, rp_reg);
                            state_next = S_PRIME;
                        end
                        else
                        begin
                            done = 1'b1;
                        end
                    end
                end
            end

            S_POP:
            begin
                popped     = rd_data;
                rp_next    = srfr_pkg::ptr_inc(rp_reg);
                done       = 1'b1;
                state_next = S_IDLE;
            end

            // lets the cr write land in the ring before the first read
            S_PRIME:
            begin
                if (rem_reg == '0)
                begin
                    rp_next    = '0;
                    wp_next    = '0;
                    status     = srfr_pkg::ST_REJECTED;
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                rp_next  = srfr_pkg::ptr_inc(rp_reg);
                rem_next = rem_reg - srfr_pkg::PTR_W'(1);
                if ((rd_data == srfr_pkg::CH_DOLLAR) &&
                    (rem_reg == srfr_pkg::PTR_W'(srfr_pkg::FRAME_TAIL + 1)))
                begin
                    tail_next  = TAIL_DEPTH;
                    state_next = S_TAIL;
                end
                else if ((rd_data == srfr_pkg::CH_DOLLAR) ||
                         (rem_reg == srfr_pkg::PTR_W'(1)))
                begin
                    rp_next    = '0;
                    wp_next    = '0;
                    status     = srfr_pkg::ST_REJECTED;
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_TAIL:
            begin
                rp_next   = srfr_pkg::ptr_inc(rp_reg);
                tail_next = tail_reg + 2'd1;
                case (tail_reg)
                    TAIL_DEPTH: depth_next = rd_data;
                    TAIL_KEY:   key_next   = rd_data;
                    default:    ;
                endcase
                if (tail_reg == TAIL_LAST)
                begin
                    status     = srfr_pkg::ST_ACCEPTED;
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rp_reg    <= '0;
            wp_reg    <= '0;
            rem_reg   <= '0;
            tail_reg  <= '0;
            depth_reg <= '0;
            key_reg   <= '0;
            send_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            rp_reg    <= rp_next;
            wp_reg    <= wp_next;
            rem_reg   <= rem_next;
            tail_reg  <= tail_next;
            depth_reg <= depth_next;
            key_reg   <= key_next;
            send_reg  <= send_next;
        end
    end

    assign stat.idle = (state_reg == S_IDLE);
    assign stat.done = done;

    assign res.status        = status;
    assign res.popped_byte   = popped;
    assign res.entry_count   = srfr_pkg::COUNT_W'(srfr_pkg::ring_held(wp_next, rp_next));
    assign res.depth_reading = depth_next;
    assign res.remote_key    = (key_next == srfr_pkg::KEY_IDLE) ? '0 : key_next;
    assign res.send_enabled  = send_next;

endmodule

### dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the serial frame ring receiver: a directed pass over
// error flags, frames, pops and flow bytes, then random phases that switch the
// mode and mix good frames, broken frames, ring fills and noise, with bursty
// input, a stalling receiver and a scoreboard that predicts every result item
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import srfr_pkg::*;

    // run sizing
    localparam int RAND_ITEMS   = 700;
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 400000;
    localparam int REPORT_MAX   = 10;

    // receiver stall patterns
    localparam int RX_STEADY   = 0;
    localparam int RX_COIN     = 1;
    localparam int RX_PERIODIC = 2;
    localparam int RX_SPARSE   = 3;

    // -----------------------------------------------------------------------
    // scoreboard: own copy of ring, pointers and frame bytes; predicts the
    // result of each accepted item and checks results in order
    // -----------------------------------------------------------------------
    class ring_rx_scoreboard;
        logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
        int                rd_ptr;
        int                wr_ptr;
        logic [BYTE_W-1:0] last_scanned;
        logic [BYTE_W-1:0] depth_val;
        logic [BYTE_W-1:0] key_val;
        logic [BYTE_W-1:0] tail_val;
        logic              send_flag;
        logic              frame_mode;
        rsp_item_t         pending_results[$];
        int                mismatches;
        int                checked;
        int                n_accepted;
        int                n_rejected;
        int                n_popped;
        int                n_empty;
        int                n_dropped;
        int                n_wraps;

        function new();
            foreach (ring_mem[i])
            begin
                ring_mem[i] = '0;
            end
            rd_ptr       = 0;
            wr_ptr       = 0;
            last_scanned = '0;
            depth_val    = '0;
            key_val      = '0;
            tail_val     = '0;
            send_flag    = 1'b1;
            frame_mode   = 1'b1;
            mismatches   = 0;
            checked      = 0;
            n_accepted   = 0;
            n_rejected   = 0;
            n_popped     = 0;
            n_empty      = 0;
            n_dropped    = 0;
            n_wraps      = 0;
        endfunction

        function int held();
            return (wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
        endfunction

        function void push(input logic [BYTE_W-1:0] b);
            ring_mem[wr_ptr] = b;
            wr_ptr = (wr_ptr + 1) % RING_DEPTH;
            if (wr_ptr == 0)
            begin
                n_wraps++;
            end
        endfunction

        function logic [BYTE_W-1:0] pull();
            logic [BYTE_W-1:0] b;
            b = ring_mem[rd_ptr];
            rd_ptr = (rd_ptr + 1) % RING_DEPTH;
            return b;
        endfunction

        // work out the result of one accepted item and queue it
        function void note_item(input req_item_t it);
            rsp_item_t         exp;
            logic [BYTE_W-1:0] b;
            int                n;
            exp = '0;
            b   = it.rx_byte;
            if (it.opcode == OP_POP)
            begin
                if (held() == 0)
                begin
                    exp.status = ST_EMPTY;
                    n_empty++;
                end
                else
                begin
                    exp.popped_byte = pull();
                    n_popped++;
                end
            end
            else if (frame_mode == 1'b0)
            begin
                if (b == CH_XON)
                begin
                    send_flag = 1'b1;
                end
                else if (b == CH_XOFF)
                begin
                    send_flag = 1'b0;
                end
                else if (b != CH_NUL)
                begin
                    push(b);
                end
            end
            else if (it.parity_error)
            begin
                exp.status = ST_PARITY;
                n_dropped++;
            end
            else if (it.stop_error)
            begin
                exp.status = ST_STOP;
                n_dropped++;
            end
            else if (it.overrun_error)
            begin
                exp.status = ST_OVERRUN;
                n_dropped++;
            end
            else
            begin
                push(b);
                if (b == CH_CR)
                begin
                    n = held();
                    for (int k = 0; k < n; k++)
                    begin
                        last_scanned = pull();
                        if (last_scanned == CH_DOLLAR)
                        begin
                            break;
                        end
                    end
                    if (last_scanned == CH_DOLLAR && held() == FRAME_TAIL)
                    begin
                        depth_val  = pull();
                        key_val    = pull();
                        tail_val   = pull();
                        exp.status = ST_ACCEPTED;
                        n_accepted++;
                    end
                    else
                    begin
                        rd_ptr     = 0;
                        wr_ptr     = 0;
                        exp.status = ST_REJECTED;
                        n_rejected++;
                    end
                end
            end
            exp.entry_count   = COUNT_W'(held());
            exp.depth_reading = depth_val;
            exp.remote_key    = (key_val == KEY_IDLE) ? '0 : key_val;
            exp.send_enabled  = send_flag;
            pending_results.push_back(exp);
        endfunction

        function void check_result(input rsp_item_t got);
            rsp_item_t exp;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("mismatch %0d: unexpected result, status %0d count %0d",
                             mismatches, got.status, got.entry_count);
                end
                return;
            end
            exp = pending_results.pop_front();
            checked++;
            if (got.status !== exp.status || got.popped_byte !== exp.popped_byte ||
                got.entry_count !== exp.entry_count ||
                got.depth_reading !== exp.depth_reading ||
                got.remote_key !== exp.remote_key || got.send_enabled !== exp.send_enabled)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("mismatch %0d (exp/act): status %0d/%0d popped %02h/%02h",
                             mismatches, exp.status, got.status, exp.popped_byte,
                             got.popped_byte);
                    $display("  count %0d/%0d depth %02h/%02h key %02h/%02h send %0b/%0b",
                             exp.entry_count, got.entry_count,
                             exp.depth_reading, got.depth_reading, exp.remote_key,
                             got.remote_key, exp.send_enabled, got.send_enabled);
                end
            end
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // clock, reset, channels, block
    // -----------------------------------------------------------------------
    logic clk;
    logic rst_n;

    srfr_req_if req_ch ();
    srfr_rsp_if rsp_ch ();
    srfr_cfg_if cfg_ch ();

    serial_frame_ring_receiver_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    ring_rx_scoreboard sb;

    int cycle_count   = 0;
    int items_sent    = 0;
    int burst_left    = 0;
    int mode_writes   = 0;
    int long_stalls   = 0;
    bit hold_off_req  = 1'b0;

    // 20 ns period
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // watchdog: a hung block ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // item builders
    // -----------------------------------------------------------------------
    function automatic req_item_t byte_item(input logic [BYTE_W-1:0] b,
                                            input logic [2:0] flags);
        req_item_t it;
        it.opcode        = OP_BYTE;
        it.rx_byte       = b;
        it.parity_error  = flags[2];
        it.stop_error    = flags[1];
        it.overrun_error = flags[0];
        return it;
    endfunction

    function automatic req_item_t pop_item();
        req_item_t it;
        it        = '0;
        it.opcode = OP_POP;
        // payload is don't-care on a pop, so let it wiggle
        it.rx_byte = BYTE_W'($urandom_range(0, 255));
        return it;
    endfunction

    // any byte that neither ends nor opens a frame
    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] b;
        do
        begin
            b = BYTE_W'($urandom_range(0, 255));
        end
        while (b == CH_CR || b == CH_DOLLAR);
        return b;
    endfunction

    // -----------------------------------------------------------------------
    // sender: bursts of random length, random gaps between them
    // -----------------------------------------------------------------------
    task automatic send_item(input req_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.valid         <= 1'b1;
        req_ch.opcode        <= it.opcode;
        req_ch.rx_byte       <= it.rx_byte;
        req_ch.parity_error  <= it.parity_error;
        req_ch.stop_error    <= it.stop_error;
        req_ch.overrun_error <= it.overrun_error;
        do
        begin
            @(posedge clk);
        end
        while (req_ch.ready !== 1'b1);
        sb.note_item(it);
        items_sent++;
    endtask

    // sender stops until every queued result has come back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (sb.pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // mode register write, only called with the block idle
    task automatic write_frame_mode(input logic mode);
        @(posedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.frame_mode <= mode;
        do
        begin
            @(posedge clk);
        end
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid  <= 1'b0;
        sb.frame_mode = mode;
        mode_writes++;
    endtask

    // -----------------------------------------------------------------------
    // sequences
    // -----------------------------------------------------------------------

    // optional junk, '$', depth, key, cr; dropped error bytes may sneak in
    task automatic good_frame();
        logic [BYTE_W-1:0] depth_b;
        logic [BYTE_W-1:0] key_b;
        repeat ($urandom_range(0, 4)) send_item(byte_item(plain_byte(), 3'b000));
        send_item(byte_item(CH_DOLLAR, 3'b000));
        do
        begin
            depth_b = BYTE_W'($urandom_range(0, 255));
        end
        while (depth_b == CH_CR);
        send_item(byte_item(depth_b, 3'b000));
        if ($urandom_range(0, 9) == 0)
        begin
            send_item(byte_item(BYTE_W'($urandom_range(0, 255)),
                                3'($urandom_range(1, 7))));
        end
        if ($urandom_range(0, 3) == 0)
        begin
            key_b = KEY_IDLE;
        end
        else
        begin
            do
            begin
                key_b = BYTE_W'($urandom_range(0, 255));
            end
            while (key_b == CH_CR);
        end
        send_item(byte_item(key_b, 3'b000));
        send_item(byte_item(CH_CR, 3'b000));
    endtask

    // optional '$' and a tail of random length, mostly the wrong one
    task automatic broken_frame();
        if ($urandom_range(0, 1) == 0)
        begin
            send_item(byte_item(CH_DOLLAR, 3'b000));
        end
        repeat ($urandom_range(0, 5)) send_item(byte_item(plain_byte(), 3'b000));
        send_item(byte_item(CH_CR, 3'b000));
    endtask

    task automatic pop_run(input int n);
        repeat (n) send_item(pop_item());
    endtask

    // fill the ring; in frame mode a closing cr may land with the pointers met
    task automatic fill_ring(input int n, input bit close_with_cr);
        repeat (n) send_item(byte_item(plain_byte(), 3'b000));
        if (close_with_cr)
        begin
            send_item(byte_item(CH_CR, 3'b000));
        end
    endtask

    task automatic noise_run(input int n);
        req_item_t it;
        repeat (n)
        begin
            it.opcode        = 1'($urandom_range(0, 1));
            it.rx_byte       = BYTE_W'($urandom_range(0, 255));
            it.parity_error  = 1'($urandom_range(0, 1));
            it.stop_error    = 1'($urandom_range(0, 1));
            it.overrun_error = 1'($urandom_range(0, 1));
            send_item(it);
        end
    endtask

    // flow mode bytes: xon, xoff and nul often, error flags random
    task automatic flow_bytes(input int n);
        int                r;
        logic [BYTE_W-1:0] b;
        repeat (n)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
            begin
                b = CH_XON;
            end
            else if (r == 1)
            begin
                b = CH_XOFF;
            end
            else if (r == 2)
            begin
                b = CH_NUL;
            end
            else
            begin
                b = BYTE_W'($urandom_range(0, 255));
            end
            send_item(byte_item(b, 3'($urandom_range(0, 7))));
        end
    endtask

    task automatic frame_sequence();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            good_frame();
        end
        else if (r < 60)
        begin
            broken_frame();
        end
        else if (r < 72)
        begin
            pop_run($urandom_range(1, 4));
        end
        else if (r < 80)
        begin
            repeat ($urandom_range(1, 3))
                send_item(byte_item(BYTE_W'($urandom_range(0, 255)),
                                    3'($urandom_range(1, 7))));
        end
        else if (r < 85)
        begin
            // half the time aim the cr at the slot where the pointers meet
            if ($urandom_range(0, 1) == 0)
            begin
                n = RING_DEPTH - 1 - sb.held();
            end
            else
            begin
                n = $urandom_range(50, 70);
            end
            fill_ring(n, 1'b1);
        end
        else
        begin
            noise_run($urandom_range(1, 4));
        end
    endtask

    task automatic flow_sequence();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
        begin
            pop_run($urandom_range(1, 5));
        end
        else if (r < 26)
        begin
            fill_ring($urandom_range(60, 70), 1'b0);
        end
        else if (r < 36)
        begin
            noise_run($urandom_range(1, 4));
        end
        else
        begin
            flow_bytes($urandom_range(1, 8));
        end
    endtask

    // -----------------------------------------------------------------------
    // receiver: stall pattern of its own, plus long hold-offs on request
    // -----------------------------------------------------------------------
    initial
    begin
        int seg_left;
        int seg_mode;
        int period;
        rsp_ch.ready <= 1'b0;
        seg_left = 0;
        seg_mode = RX_STEADY;
        period   = 2;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                // block fills up behind the held result and stalls its input
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
                long_stalls++;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_mode = $urandom_range(RX_STEADY, RX_SPARSE);
                    seg_left = $urandom_range(20, 200);
                    period   = $urandom_range(2, 9);
                end
                seg_left--;
                case (seg_mode)
                    RX_STEADY:   rsp_ch.ready <= 1'b1;
                    RX_COIN:     rsp_ch.ready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: rsp_ch.ready <= ((cycle_count % period) != 0);
                    default:     rsp_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // -----------------------------------------------------------------------
    // result monitor
    // -----------------------------------------------------------------------
    initial
    begin
        rsp_item_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                got.status        = rsp_ch.status;
                got.popped_byte   = rsp_ch.popped_byte;
                got.entry_count   = rsp_ch.entry_count;
                got.depth_reading = rsp_ch.depth_reading;
                got.remote_key    = rsp_ch.remote_key;
                got.send_enabled  = rsp_ch.send_enabled;
                sb.check_result(got);
            end
        end
    end

    // -----------------------------------------------------------------------
    // main flow
    // -----------------------------------------------------------------------
    initial
    begin
        int phase;
        int directed_items;
        int failures;
        sb = new();
        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.opcode        <= OP_BYTE;
        req_ch.rx_byte       <= '0;
        req_ch.parity_error  <= 1'b0;
        req_ch.stop_error    <= 1'b0;
        req_ch.overrun_error <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.frame_mode    <= 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: frame mode (reset value, written anyway)
        write_frame_mode(1'b1);
        send_item(pop_item());                          // pop from empty ring
        send_item(byte_item(8'h41, 3'b111));            // parity wins
        send_item(byte_item(8'h42, 3'b011));            // stop over overrun
        send_item(byte_item(8'h43, 3'b001));            // overrun alone
        send_item(byte_item(CH_DOLLAR, 3'b000));        // good frame, idle key
        send_item(byte_item(8'hFF, 3'b000));
        send_item(byte_item(KEY_IDLE, 3'b000));
        send_item(byte_item(CH_CR, 3'b000));
        send_item(byte_item(CH_DOLLAR, 3'b000));        // good frame, zero depth
        send_item(byte_item(8'h00, 3'b000));
        send_item(byte_item(8'h55, 3'b000));
        send_item(byte_item(CH_CR, 3'b000));
        send_item(byte_item(8'h80, 3'b000));            // no dollar: rejected
        send_item(byte_item(CH_CR, 3'b000));
        send_item(byte_item(8'h7E, 3'b000));
        send_item(pop_item());
        send_item(byte_item(CH_CR, 3'b100));            // errored cr is dropped
        send_item(byte_item(CH_DOLLAR, 3'b000));        // short tail: rejected
        send_item(byte_item(8'h01, 3'b000));
        send_item(byte_item(CH_CR, 3'b000));
        drain_results();

        // directed: flow mode, flags ignored there
        write_frame_mode(1'b0);
        send_item(byte_item(CH_XOFF, 3'b000));
        send_item(byte_item(CH_NUL, 3'b111));
        send_item(byte_item(8'hFF, 3'b111));
        send_item(byte_item(CH_XON, 3'b000));
        send_item(pop_item());
        send_item(pop_item());
        directed_items = items_sent;

        // random phases, mode switched between them with the block idle
        phase = 0;
        while (items_sent - directed_items < RAND_ITEMS)
        begin
            drain_results();
            write_frame_mode((phase % 3 == 1) ? 1'b0 : 1'b1);
            if (phase == 1 || phase == 4)
            begin
                hold_off_req = 1'b1;
            end
            repeat ($urandom_range(8, 20))
            begin
                if (sb.frame_mode)
                begin
                    frame_sequence();
                end
                else
                begin
                    flow_sequence();
                end
            end
            phase++;
        end

        // wind down, then give stray results time to show up
        drain_results();
        repeat (RING_DEPTH + 8) @(posedge clk);
        failures = sb.mismatches + sb.pending_results.size();

        $display("tb_top: %0d items, %0d results checked, %0d mode writes, %0d long stalls",
                 items_sent, sb.checked, mode_writes, long_stalls);
        $display("tb_top: frames ok %0d bad %0d, pops %0d empty %0d, dropped %0d, wraps %0d",
                 sb.n_accepted, sb.n_rejected, sb.n_popped, sb.n_empty, sb.n_dropped,
                 sb.n_wraps);
        if (failures == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
